FILE: rtl/core/ste_pkg.sv
// Shared types and constants for the surface texture extents block.
`default_nettype none

package ste_pkg;

  // Projections carry 20 fraction bits (Q.20 texels) in 42 bits.
  localparam int unsigned FRAC_BITS = 20;
  localparam int unsigned ACC_W     = 42;

  typedef logic signed [ACC_W-1:0] acc_t;

  // Accumulators restart at the extremes of the signed range.
  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [3:0] {
    CFG_S_COEF_X = 4'd0,
    CFG_S_COEF_Y = 4'd1,
    CFG_S_COEF_Z = 4'd2,
    CFG_S_OFFSET = 4'd3,
    CFG_T_COEF_X = 4'd4,
    CFG_T_COEF_Y = 4'd5,
    CFG_T_COEF_Z = 4'd6,
    CFG_T_OFFSET = 4'd7
  } cfg_idx_e;

  // Per-stage control that travels beside the data path.
  typedef struct packed {
    logic valid;
    logic last;
    logic special;
  } ctl_t;

  // Finished values for one texture axis.
  typedef struct packed {
    logic signed [20:0] tex_min;
    logic [15:0]        extent;
    logic [12:0]        light;
    logic               over;
  } axis_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/surface_texture_extents.sv
// Top level of the surface texture extents block.
//
// Vertices of a polygon enter one per beat on the input channel (in_valid_i,
// in_stall_o); last_vertex marks the final one. Each vertex is projected onto
// the S and T texture axes set by the eight configuration registers, written
// through the cfg channel, which is always ready. The user must write
// registers only with no polygon in flight; the block does not enforce it.
// One result beat leaves on the output channel (out_valid_o, out_stall_i) per
// polygon: block-aligned texture minima, extents, lightmap size and the
// extent error flag.
// The pipeline has five register stages: input, products, projection sum,
// min/max accumulation and finishing; the last vertex passes through them in
// that order. One vertex is accepted every cycle unless the pipeline holds;
// the six projection multipliers work in parallel and each stage holds one
// vertex. When the receiver stalls a waiting result, the whole pipeline
// holds and in_stall_o rises in the same cycle; vertices that produce no
// result keep flowing whenever no result is held.
// Reset clears all stage valid bits, zeroes the configuration registers and
// restarts the accumulators at the extremes of their range.
`default_nettype none

module surface_texture_extents #(
  parameter int unsigned BLOCK_SHIFT  = 4,
  parameter int unsigned EXTENT_LIMIT = 512
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write channel.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [3:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  // Vertex input channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [23:0] in_pos_x_i,
  input  wire logic signed [23:0] in_pos_y_i,
  input  wire logic signed [23:0] in_pos_z_i,
  input  wire logic               in_last_vertex_i,
  input  wire logic               in_special_surface_i,
  // Result output channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [20:0]      out_tex_min_s_o,
  output logic signed [20:0]      out_tex_min_t_o,
  output logic [15:0]             out_extent_s_o,
  output logic [15:0]             out_extent_t_o,
  output logic [12:0]             out_light_width_o,
  output logic [12:0]             out_light_height_o,
  output logic                    out_extent_error_o
);

  logic signed [15:0] s_coef_x_q, s_coef_y_q, s_coef_z_q;
  logic signed [15:0] t_coef_x_q, t_coef_y_q, t_coef_z_q;
  logic signed [23:0] s_offset_q, t_offset_q;

  logic               adv;
  ste_pkg::ctl_t      ctl1_q, ctl2_q, ctl3_q;
  logic signed [23:0] pos_x_q, pos_y_q, pos_z_q;
  ste_pkg::acc_t      proj_s, proj_t;

  ste_pkg::acc_t      min_s_q, max_s_q, min_t_q, max_t_q;
  ste_pkg::acc_t      min_s_d, max_s_d, min_t_d, max_t_d;
  ste_pkg::acc_t      fin_min_s_q, fin_max_s_q, fin_min_t_q, fin_max_t_q;
  logic               fin_valid_q, fin_special_q;

  ste_pkg::axis_res_t res_s, res_t;
  logic               out_valid_q;

  // Configuration registers; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_coef_x_q <= '0;
      s_coef_y_q <= '0;
      s_coef_z_q <= '0;
      s_offset_q <= '0;
      t_coef_x_q <= '0;
      t_coef_y_q <= '0;
      t_coef_z_q <= '0;
      t_offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ste_pkg::CFG_S_COEF_X: s_coef_x_q <= cfg_data_i[15:0];
        ste_pkg::CFG_S_COEF_Y: s_coef_y_q <= cfg_data_i[15:0];
        ste_pkg::CFG_S_COEF_Z: s_coef_z_q <= cfg_data_i[15:0];
        ste_pkg::CFG_S_OFFSET: s_offset_q <= cfg_data_i;
        ste_pkg::CFG_T_COEF_X: t_coef_x_q <= cfg_data_i[15:0];
        ste_pkg::CFG_T_COEF_Y: t_coef_y_q <= cfg_data_i[15:0];
        ste_pkg::CFG_T_COEF_Z: t_coef_z_q <= cfg_data_i[15:0];
        ste_pkg::CFG_T_OFFSET: t_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a result is waiting and stalled.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (adv) begin
      ctl1_q <= '{valid: in_valid_i, last: in_last_vertex_i,
                  special: in_special_surface_i};
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      pos_x_q <= in_pos_x_i;
      pos_y_q <= in_pos_y_i;
      pos_z_q <= in_pos_z_i;
    end
  end

  // Product and sum stages for each axis.
  ste_project u_proj_s (
    .clk_i    (clk_i),
    .en_i     (adv),
    .pos_x_i  (pos_x_q),
    .pos_y_i  (pos_y_q),
    .pos_z_i  (pos_z_q),
    .coef_x_i (s_coef_x_q),
    .coef_y_i (s_coef_y_q),
    .coef_z_i (s_coef_z_q),
    .offset_i (s_offset_q),
    .proj_o   (proj_s)
  );

  ste_project u_proj_t (
    .clk_i    (clk_i),
    .en_i     (adv),
    .pos_x_i  (pos_x_q),
    .pos_y_i  (pos_y_q),
    .pos_z_i  (pos_z_q),
    .coef_x_i (t_coef_x_q),
    .coef_y_i (t_coef_y_q),
    .coef_z_i (t_coef_z_q),
    .offset_i (t_offset_q),
    .proj_o   (proj_t)
  );

  // Merge the current projection into the running bounds.
  always_comb begin
    min_s_d = (proj_s < min_s_q) ? proj_s : min_s_q;
    max_s_d = (proj_s > max_s_q) ? proj_s : max_s_q;
    min_t_d = (proj_t < min_t_q) ? proj_t : min_t_q;
    max_t_d = (proj_t > max_t_q) ? proj_t : max_t_q;
  end

  // Accumulation stage: the last vertex hands the bounds on and restarts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_s_q     <= ste_pkg::ACC_MAX;
      max_s_q     <= ste_pkg::ACC_MIN;
      min_t_q     <= ste_pkg::ACC_MAX;
      max_t_q     <= ste_pkg::ACC_MIN;
      fin_valid_q <= 1'b0;
    end else if (adv) begin
      fin_valid_q <= ctl3_q.valid && ctl3_q.last;
      if (ctl3_q.valid) begin
        if (ctl3_q.last) begin
          min_s_q <= ste_pkg::ACC_MAX;
          max_s_q <= ste_pkg::ACC_MIN;
          min_t_q <= ste_pkg::ACC_MAX;
          max_t_q <= ste_pkg::ACC_MIN;
        end else begin
          min_s_q <= min_s_d;
          max_s_q <= max_s_d;
          min_t_q <= min_t_d;
          max_t_q <= max_t_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ctl3_q.valid && ctl3_q.last) begin
      fin_min_s_q   <= min_s_d;
      fin_max_s_q   <= max_s_d;
      fin_min_t_q   <= min_t_d;
      fin_max_t_q   <= max_t_d;
      fin_special_q <= ctl3_q.special;
    end
  end

  // Finishing logic for both axes.
  ste_finish #(
    .BLOCK_SHIFT  (BLOCK_SHIFT),
    .EXTENT_LIMIT (EXTENT_LIMIT)
  ) u_fin_s (
    .min_i (fin_min_s_q),
    .max_i (fin_max_s_q),
    .res_o (res_s)
  );

  ste_finish #(
    .BLOCK_SHIFT  (BLOCK_SHIFT),
    .EXTENT_LIMIT (EXTENT_LIMIT)
  ) u_fin_t (
    .min_i (fin_min_t_q),
    .max_i (fin_max_t_q),
    .res_o (res_t)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fin_valid_q) begin
      out_tex_min_s_o    <= res_s.tex_min;
      out_tex_min_t_o    <= res_t.tex_min;
      out_extent_s_o     <= res_s.extent;
      out_extent_t_o     <= res_t.extent;
      out_light_width_o  <= res_s.light;
      out_light_height_o <= res_t.light;
      out_extent_error_o <= !fin_special_q && (res_s.over || res_t.over);
    end
  end

  assign out_valid_o = out_valid_q;

  // A finished polygon leaves the accumulators at their restart values.
  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ctl3_q.valid && ctl3_q.last) |=>
      (min_s_q == ste_pkg::ACC_MAX && max_t_q == ste_pkg::ACC_MIN))
    else $error("accumulators did not restart after the last vertex");

  // A lightmap always spans at least one sample.
  a_light_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_light_width_o != 13'd0 && out_light_height_o != 13'd0))
    else $error("lightmap size of zero");

  // An unsaturated extent is a whole number of blocks.
  a_extent_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_extent_s_o != 16'hFFFF) |->
      ((32'(out_extent_s_o) & ((32'd1 << BLOCK_SHIFT) - 32'd1)) == 32'd0))
    else $error("S extent is not block aligned");

  // The error flag needs an extent beyond the limit.
  a_error_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_extent_error_o) |->
      (32'(out_extent_s_o) > EXTENT_LIMIT || 32'(out_extent_t_o) > EXTENT_LIMIT
       || out_extent_s_o == 16'hFFFF || out_extent_t_o == 16'hFFFF))
    else $error("extent error without an oversized extent");

endmodule

`default_nettype wire

FILE: rtl/core/ste_project.sv
// Two-stage projection of a vertex onto one texture axis.
`default_nettype none

module ste_project (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic signed [23:0] pos_z_i,
  input  wire logic signed [15:0] coef_x_i,
  input  wire logic signed [15:0] coef_y_i,
  input  wire logic signed [15:0] coef_z_i,
  input  wire logic signed [23:0] offset_i,
  output ste_pkg::acc_t           proj_o
);

  logic signed [39:0] prod_x_d, prod_y_d, prod_z_d;
  logic signed [39:0] prod_x_q, prod_y_q, prod_z_q;
  ste_pkg::acc_t      proj_d, proj_q;

  // Three independent products, one multiplier each.
  assign prod_x_d = pos_x_i * coef_x_i;
  assign prod_y_d = pos_y_i * coef_y_i;
  assign prod_z_d = pos_z_i * coef_z_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
    end
  end

  // The Q16.8 offset is aligned to Q.20 by a shift of twelve.
  assign proj_d = ste_pkg::acc_t'(prod_x_q) + ste_pkg::acc_t'(prod_y_q)
                + ste_pkg::acc_t'(prod_z_q) + (ste_pkg::acc_t'(offset_i) <<< 12);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      proj_q <= proj_d;
    end
  end

  assign proj_o = proj_q;

endmodule

`default_nettype wire

FILE: rtl/core/ste_finish.sv
// Block rounding, extent and lightmap size for one texture axis.
`default_nettype none

module ste_finish #(
  parameter int unsigned BLOCK_SHIFT  = 4,
  parameter int unsigned EXTENT_LIMIT = 512
) (
  input  wire ste_pkg::acc_t  min_i,
  input  wire ste_pkg::acc_t  max_i,
  output ste_pkg::axis_res_t  res_o
);

  localparam int unsigned Sh = ste_pkg::FRAC_BITS + BLOCK_SHIFT;
  localparam logic signed [51:0] RoundAdd  = (52'sd1 <<< Sh) - 52'sd1;
  localparam logic signed [51:0] TexMinMax = 52'sd1048575;
  localparam logic signed [51:0] TexMinMin = -52'sd1048576;
  localparam logic signed [51:0] ExtSat    = 52'sd65535;
  localparam logic signed [51:0] LightSat  = 52'sd4096;
  localparam logic signed [51:0] Limit     = 52'(EXTENT_LIMIT);

  logic signed [51:0] mn_w, mx_w, bmin, bmax, span, tm, ex, lw;

  // Arithmetic shift floors; adding one block less one before it ceils.
  always_comb begin
    mn_w = 52'(min_i);
    mx_w = 52'(max_i);
    bmin = mn_w >>> Sh;
    bmax = (mx_w + RoundAdd) >>> Sh;
    span = bmax - bmin;
    tm   = bmin <<< BLOCK_SHIFT;
    ex   = span <<< BLOCK_SHIFT;
    lw   = span + 52'sd1;
  end

  // Saturate each field to its output range.
  always_comb begin
    priority if (tm > TexMinMax) begin
      res_o.tex_min = TexMinMax[20:0];
    end else if (tm < TexMinMin) begin
      res_o.tex_min = TexMinMin[20:0];
    end else begin
      res_o.tex_min = tm[20:0];
    end
    res_o.extent = (ex > ExtSat) ? 16'hFFFF : ex[15:0];
    res_o.light  = (lw > LightSat) ? 13'd4096 : lw[12:0];
    res_o.over   = (ex > Limit);
  end

endmodule

`default_nettype wire
